// ===== rtl/vng_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the vertex normal generator.
// No dependencies; every other file imports this package.
package vng_pkg;

    localparam int IDX_W            = 10;    // vertex index width
    localparam int POS_W            = 16;    // Q7.8 coordinate width
    localparam int ACC_W            = 40;    // accumulator width, Q.16
    localparam int CRS_W            = 34;    // cross product component width
    localparam int NRM_W            = 16;    // Q1.14 normal component width
    localparam int CNT_W            = 11;    // vertex_count register width
    localparam int INDEX_SPAN       = 1024;  // indices the index field can reach
    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam logic [CNT_W-1:0] VCOUNT_RST = 11'd1024;
    localparam logic [NRM_W-1:0] NRM_ONE    = 16'd16384;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_TRI  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ZERO  = 2'd2,
        ST_RSVD  = 2'd3
    } t_status;

    // Result of the normalizer toward the sequencer.
    typedef struct packed {
        logic                  done;
        logic                  zero;
        logic [2:0][NRM_W-1:0] n;
    } t_norm_res;

endpackage

// ===== rtl/vng_cross.sv =====
`timescale 1ns / 1ps
// Cross product (b-a) x (c-a) of three corner positions, one component per cycle
// through two shared multipliers. Depends on vng_pkg.
module vng_cross (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [2:0][vng_pkg::POS_W-1:0]      i_pa,
    input  logic [2:0][vng_pkg::POS_W-1:0]      i_pb,
    input  logic [2:0][vng_pkg::POS_W-1:0]      i_pc,
    output logic                                o_done,
    output logic [2:0][vng_pkg::CRS_W-1:0]      o_cross
);
    import vng_pkg::*;

    logic                  r_busy;
    logic [1:0]            r_k;
    logic [2:0][POS_W:0]   r_e1;
    logic [2:0][POS_W:0]   r_e2;
    logic signed [CRS_W-1:0] r_p1;
    logic signed [CRS_W-1:0] r_p2;
    logic signed [POS_W:0] w_a1, w_b1, w_a2, w_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k    <= 2'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_k    <= 2'd0;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
            if (r_k == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Operand pairs for component r_k.
    always_comb begin
        unique case (r_k)
            2'd0: begin
                w_a1 = $signed(r_e1[1]); w_b1 = $signed(r_e2[2]);
                w_a2 = $signed(r_e1[2]); w_b2 = $signed(r_e2[1]);
            end
            2'd1: begin
                w_a1 = $signed(r_e1[2]); w_b1 = $signed(r_e2[0]);
                w_a2 = $signed(r_e1[0]); w_b2 = $signed(r_e2[2]);
            end
            default: begin
                w_a1 = $signed(r_e1[0]); w_b1 = $signed(r_e2[1]);
                w_a2 = $signed(r_e1[1]); w_b2 = $signed(r_e2[0]);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= {i_pb[k][POS_W-1], i_pb[k]} - {i_pa[k][POS_W-1], i_pa[k]};
                r_e2[k] <= {i_pc[k][POS_W-1], i_pc[k]} - {i_pa[k][POS_W-1], i_pa[k]};
            end
        end
        r_p1 <= CRS_W'(w_a1 * w_b1);
        r_p2 <= CRS_W'(w_a2 * w_b2);
        // products registered in r_p1/r_p2 during step k land in o_cross[k]
        if (r_busy && r_k != 2'd0) begin
            o_cross[2'(r_k - 2'd1)] <= r_p1 - r_p2;
        end
    end

    assign o_done = r_busy && (r_k == 2'd3);

endmodule

// ===== rtl/vng_norm.sv =====
`timescale 1ns / 1ps
// Iterative normalizer: range shift, sum of squares, bit-serial square root and
// restoring division to a rounded Q1.14 unit vector. Depends on vng_pkg.
module vng_norm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [2:0][vng_pkg::ACC_W-1:0]     i_acc,
    output vng_pkg::t_norm_res                 o_res
);
    import vng_pkg::*;

    typedef enum logic [5:0] {
        N_IDLE  = 6'b000001,
        N_SHIFT = 6'b000010,
        N_SQ    = 6'b000100,
        N_SQRT  = 6'b001000,
        N_DIV   = 6'b010000,
        N_DONE  = 6'b100000
    } t_nstate;

    t_nstate               r_state;
    logic [2:0][ACC_W-1:0] r_m;
    logic [2:0]            r_neg;
    logic                  r_zero;
    logic [1:0]            r_k;
    logic [61:0]           r_sq;
    logic [63:0]           r_s;
    logic [63:0]           r_res;
    logic [63:0]           r_bit;
    logic [4:0]            r_dcnt;
    logic [31:0]           r_rem;
    logic [15:0]           r_nlo;
    logic [15:0]           r_q;
    logic [2:0][NRM_W-1:0] r_n;

    logic [ACC_W-1:0] w_mx;
    logic [1:0]       w_ksel;
    logic [30:0]      w_msel;
    logic [63:0]      w_trial;
    logic [31:0]      w_len;
    logic [45:0]      w_num;
    logic [32:0]      w_dtry;
    logic             w_ge;
    logic [15:0]      w_qv;
    logic [15:0]      w_qc;

    always_comb begin
        w_mx = r_m[0];
        if (r_m[1] > w_mx) w_mx = r_m[1];
        if (r_m[2] > w_mx) w_mx = r_m[2];
        w_ksel  = (r_k == 2'd3) ? 2'd0 : r_k;
        w_msel  = r_m[w_ksel][30:0];
        w_trial = r_res + r_bit;
        w_len   = r_res[31:0];
        w_num   = {w_msel, 14'b0} + 46'(w_len[31:1]);
        w_dtry  = {r_rem, r_nlo[15]};
        w_ge    = w_dtry >= {1'b0, w_len};
        w_qv    = {r_q[14:0], w_ge};
        w_qc    = (w_qv > NRM_ONE) ? NRM_ONE : w_qv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_k     <= 2'd0;
            r_dcnt  <= 5'd0;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    priority if (w_mx == '0) begin
                        r_state <= N_DONE;
                    end else if (w_mx[ACC_W-1:31] != '0) begin
                        // too large: drop one bit of every component
                    end else if (!w_mx[30]) begin
                        // too small: advance every component by one bit
                    end else begin
                        r_state <= N_SQ;
                        r_k     <= 2'd0;
                    end
                end
                N_SQ: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_bit[0]) begin
                        r_state <= N_DIV;
                        r_k     <= 2'd0;
                        r_dcnt  <= 5'd0;
                    end
                end
                N_DIV: begin
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd16) begin
                        r_dcnt <= 5'd0;
                        r_k    <= r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            r_state <= N_DONE;
                        end
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: begin
                    r_state <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            N_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= i_acc[k][ACC_W-1];
                    r_m[k]   <= i_acc[k][ACC_W-1] ? ACC_W'(0) - i_acc[k] : i_acc[k];
                end
                r_zero <= 1'b0;
                r_n    <= '0;
            end
            N_SHIFT: begin
                priority if (w_mx == '0) begin
                    r_zero <= 1'b1;
                end else if (w_mx[ACC_W-1:31] != '0) begin
                    for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] >> 1;
                end else if (!w_mx[30]) begin
                    for (int k = 0; k < 3; k++) r_m[k] <= r_m[k] << 1;
                end else begin
                    r_s <= '0;
                end
            end
            N_SQ: begin
                if (r_k != 2'd3) begin
                    r_sq <= w_msel * w_msel;
                end
                if (r_k != 2'd0) begin
                    r_s <= r_s + {2'b0, r_sq};
                end
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            N_SQRT: begin
                if (r_s >= w_trial) begin
                    r_s   <= r_s - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            N_DIV: begin
                if (r_dcnt == 5'd0) begin
                    r_rem <= 32'(w_num[45:16]);
                    r_nlo <= w_num[15:0];
                    r_q   <= '0;
                end else begin
                    r_rem <= w_ge ? 32'(w_dtry - {1'b0, w_len}) : w_dtry[31:0];
                    r_nlo <= r_nlo << 1;
                    r_q   <= w_qv;
                    if (r_dcnt == 5'd16) begin
                        r_n[w_ksel] <= r_neg[w_ksel] ? NRM_W'(0) - w_qc : w_qc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.done = (r_state == N_DONE);
    assign o_res.zero = r_zero;
    assign o_res.n    = r_n;

endmodule

// ===== rtl/vertex_normal_generator.sv =====
`timescale 1ns / 1ps
// Vertex normal generator: sequencer, position and accumulator memories, output
// register. Depends on vng_pkg, vng_cross and vng_norm.
//
// Use: items enter on the s_axis channel, opcode in tuser (load vertex, add
// triangle, read normal, no-op). Every item gives exactly one result item on m_axis:
// status in tuser, vertex index and the Q1.14 unit normal in tdata. vertex_count
// is written through i_cfg_we / i_cfg_wdata while the block is idle; the user keeps
// to this, the block does not enforce it. One item is processed at a time, in steps:
//   load, rejected index, no-op   straight to the result register
//   triangle                      three position reads, three multiplier steps, three
//                                 accumulator updates
//   read normal                   the normalizer's range shifts, 4 square and 32 square
//                                 root steps and 3 x 17 division steps; a zero
//                                 accumulator stops after the range check
// Accumulator updates of one triangle are read-modify-write in order, so corners
// that repeat see each other's sum. After reset a clearing pass zeroes the
// accumulator memory, one entry a cycle (MEM_DEPTH entries, at most 1024);
// no item is taken meanwhile. A result waits in the output register while the
// receiver stalls; the block still takes the next item and holds its result
// until the register frees.
module vertex_normal_generator #(
    parameter int VERTEX_DEPTH = vng_pkg::VERTEX_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // index_a[9:0], index_b[19:10], index_c[29:20], pos_x[45:30], pos_y[61:46],
    // pos_z[77:62], zero fill [79:78]
    input  logic [79:0]                i_s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                 i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // vertex_index[9:0], norm_x[25:10], norm_y[41:26], norm_z[57:42], zero fill [63:58]
    output logic [63:0]                o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                 o_m_axis_tuser,
    input  logic                       i_cfg_we,
    input  logic [vng_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import vng_pkg::*;

    localparam int MEM_DEPTH = (VERTEX_DEPTH < INDEX_SPAN) ? VERTEX_DEPTH : INDEX_SPAN;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(VERTEX_DEPTH);

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_RD_A   = 13'b0000000000100,
        S_RD_B   = 13'b0000000001000,
        S_RD_C   = 13'b0000000010000,
        S_CAP    = 13'b0000000100000,
        S_MUL    = 13'b0000001000000,
        S_ACC_RD = 13'b0000010000000,
        S_ACC_WR = 13'b0000100000000,
        S_RD_ACC = 13'b0001000000000,
        S_NSTART = 13'b0010000000000,
        S_NORM   = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr_addr;
    logic [CNT_W-1:0]      r_vcount;
    logic [IDX_W-1:0]      r_ia, r_ib, r_ic;
    logic [1:0]            r_j;
    t_status               r_status;
    logic [2:0][NRM_W-1:0] r_n;
    logic [2:0][POS_W-1:0] r_pa, r_pb;
    logic                  r_out_valid;
    logic [63:0]           r_out_tdata;
    t_status               r_out_status;

    // memories: positions (no reset), accumulators (cleared by the sweep)
    logic [3*POS_W-1:0]    r_pos_mem [MEM_DEPTH];
    logic [3*POS_W-1:0]    r_pos_rd;
    logic [3*ACC_W-1:0]    r_acc_mem [MEM_DEPTH];
    logic [3*ACC_W-1:0]    r_acc_rd;

    t_op                   w_op;
    logic [IDX_W-1:0]      w_ia, w_ib, w_ic;
    logic                  w_a_ok, w_b_ok, w_c_ok;
    logic                  w_accept;
    logic [IDX_W-1:0]      w_corner;
    logic [IDX_W-1:0]      w_pos_raddr;
    logic [IDX_W-1:0]      w_acc_raddr;
    logic                  w_pos_we;
    logic                  w_acc_we;
    logic [AW-1:0]         w_acc_waddr;
    logic [3*ACC_W-1:0]    w_acc_wdata;
    logic [2:0][ACC_W-1:0] w_acc_sum;
    logic                  w_out_free;
    logic                  w_cross_start;
    logic                  w_cross_done;
    logic [2:0][CRS_W-1:0] w_cross;
    logic                  w_norm_start;
    t_norm_res             w_norm;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [CRS_W-1:0] d);
        logic [ACC_W:0] s;
        s = {acc[ACC_W-1], acc} + (ACC_W+1)'($signed(d));
        priority if (s[ACC_W] == s[ACC_W-1]) begin
            return s[ACC_W-1:0];
        end else if (s[ACC_W]) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    // input decode
    assign w_op     = t_op'(i_s_axis_tuser);
    assign w_ia     = i_s_axis_tdata[9:0];
    assign w_ib     = i_s_axis_tdata[19:10];
    assign w_ic     = i_s_axis_tdata[29:20];
    assign w_a_ok   = ({1'b0, w_ia} < r_vcount) && (32'(w_ia) < DEPTH32);
    assign w_b_ok   = ({1'b0, w_ib} < r_vcount) && (32'(w_ib) < DEPTH32);
    assign w_c_ok   = ({1'b0, w_ic} < r_vcount) && (32'(w_ic) < DEPTH32);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        unique case (r_j)
            2'd0:    w_corner = r_ia;
            2'd1:    w_corner = r_ib;
            default: w_corner = r_ic;
        endcase
        unique case (r_state)
            S_RD_A:  w_pos_raddr = r_ia;
            S_RD_B:  w_pos_raddr = r_ib;
            default: w_pos_raddr = r_ic;
        endcase
        w_acc_raddr = (r_state == S_RD_ACC) ? r_ia : w_corner;
        for (int k = 0; k < 3; k++) begin
            w_acc_sum[k] = sat_add(r_acc_rd[k*ACC_W +: ACC_W], w_cross[k]);
        end
    end

    assign w_pos_we = w_accept && (w_op == OP_LOAD) && w_a_ok;

    // accumulator write port: clearing sweep, load clear, triangle update
    always_comb begin
        priority if (r_state == S_CLEAR) begin
            w_acc_we    = 1'b1;
            w_acc_waddr = r_clr_addr;
            w_acc_wdata = '0;
        end else if (w_pos_we) begin
            w_acc_we    = 1'b1;
            w_acc_waddr = w_ia[AW-1:0];
            w_acc_wdata = '0;
        end else if (r_state == S_ACC_WR) begin
            w_acc_we    = 1'b1;
            w_acc_waddr = w_corner[AW-1:0];
            w_acc_wdata = {w_acc_sum[2], w_acc_sum[1], w_acc_sum[0]};
        end else begin
            w_acc_we    = 1'b0;
            w_acc_waddr = w_corner[AW-1:0];
            w_acc_wdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pos_we) begin
            r_pos_mem[w_ia[AW-1:0]] <= i_s_axis_tdata[77:30];
        end
        r_pos_rd <= r_pos_mem[w_pos_raddr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_waddr] <= w_acc_wdata;
        end
        r_acc_rd <= r_acc_mem[w_acc_raddr[AW-1:0]];
    end

    assign w_cross_start = (r_state == S_CAP);
    assign w_norm_start  = (r_state == S_NSTART);

    vng_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cross_start),
        .i_pa    (r_pa),
        .i_pb    (r_pb),
        .i_pc    (r_pos_rd),
        .o_done  (w_cross_done),
        .o_cross (w_cross)
    );

    vng_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_norm_start),
        .i_acc   (r_acc_rd),
        .o_res   (w_norm)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_vcount    <= VCOUNT_RST;
            r_out_valid <= 1'b0;
            r_j         <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            // load the output register, or drop the item the receiver took
            if (r_state == S_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (w_op)
                            OP_TRI:  r_state <= (w_a_ok && w_b_ok && w_c_ok) ? S_RD_A : S_OUT;
                            OP_READ: r_state <= w_a_ok ? S_RD_ACC : S_OUT;
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_RD_A:   r_state <= S_RD_B;
                S_RD_B:   r_state <= S_RD_C;
                S_RD_C:   r_state <= S_CAP;
                S_CAP:    r_state <= S_MUL;
                S_MUL: begin
                    if (w_cross_done) begin
                        r_state <= S_ACC_RD;
                        r_j     <= 2'd0;
                    end
                end
                S_ACC_RD: r_state <= S_ACC_WR;
                S_ACC_WR: begin
                    r_j     <= r_j + 2'd1;
                    r_state <= (r_j == 2'd2) ? S_OUT : S_ACC_RD;
                end
                S_RD_ACC: r_state <= S_NSTART;
                S_NSTART: r_state <= S_NORM;
                S_NORM: begin
                    if (w_norm.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold the result until the output register frees
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ia     <= w_ia;
            r_ib     <= w_ib;
            r_ic     <= w_ic;
            r_n      <= '0;
            priority if (w_op == OP_NOP) begin
                r_status <= ST_OK;
            end else if (!w_a_ok) begin
                r_status <= ST_RANGE;
            end else if (w_op == OP_TRI && !(w_b_ok && w_c_ok)) begin
                r_status <= ST_RANGE;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (r_state == S_RD_B) begin
            r_pa <= r_pos_rd;
        end
        if (r_state == S_RD_C) begin
            r_pb <= r_pos_rd;
        end
        if (r_state == S_NORM && w_norm.done) begin
            if (w_norm.zero) begin
                r_status <= ST_ZERO;
            end else begin
                r_n <= w_norm.n;
            end
        end
        if (r_state == S_OUT && w_out_free) begin
            r_out_status <= r_status;
            r_out_tdata  <= {6'b0, r_n[2], r_n[1], r_n[0], r_ia};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_status;

    // the cross unit finishes only while the sequencer waits for it
    a_cross_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cross_done |-> r_state == S_MUL)
        else $error("cross product finished outside its wait state");

    // the normalizer finishes only while the sequencer waits for it
    a_norm_done_in_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_norm.done |-> r_state == S_NORM)
        else $error("normalizer finished outside its wait state");

    // a result that is not an ok status carries a zero normal
    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> o_m_axis_tdata[57:10] == '0)
        else $error("normal not zero on a failed item");

    // a triangle updates no more than three corners before its result
    a_three_corners: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC_WR) |-> r_j != 2'd3)
        else $error("corner counter out of range");

    // nothing is accepted during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !$past(w_accept))
        else $error("item accepted while clearing");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench of vertex_normal_generator: directed and random mesh items checked
// against an in-bench normal predictor. Depends on vng_pkg and the block's RTL.
module tb_top;
    import vng_pkg::*;

    // one expected result item
    typedef struct {
        t_status          status;
        logic [IDX_W-1:0] vidx;
        logic [NRM_W-1:0] nx, ny, nz;
    } t_normal_exp;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [79:0]         i_s_axis_tdata = '0;
    logic [1:0]          i_s_axis_tuser = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [63:0]         o_m_axis_tdata;
    logic [1:0]          o_m_axis_tuser;
    logic                i_cfg_we = 1'b0;
    logic [CNT_W-1:0]    i_cfg_wdata = '0;

    // predictor state
    logic signed [POS_W-1:0] pos_mem [INDEX_SPAN][3];
    logic signed [ACC_W-1:0] acc_mem [INDEX_SPAN][3];
    bit                      loaded  [INDEX_SPAN];
    int unsigned             vcount;

    t_normal_exp normal_q[$];
    int          mismatch_cnt = 0;
    bit          rx_quiet = 1'b0;     // idling of the result side on/off
    bit          tx_quiet = 1'b0;
    int          hold_off = 0;        // cycles the receiver still holds off

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vertex_normal_generator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    function automatic bit index_ok(logic [IDX_W-1:0] i);
        return i < vcount;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_sum(logic signed [ACC_W-1:0] a,
                                                       logic signed [63:0] d);
        logic signed [63:0] s;
        s = 64'(a) + d;
        if (s > 64'sd549755813887) s = 64'sd549755813887;
        if (s < -64'sd549755813888) s = -64'sd549755813888;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit-length scaling of one accumulator; returns 0 when it is all zero.
    function automatic bit unit_normal(int v, output logic [NRM_W-1:0] n [3]);
        logic [63:0] m [3];
        bit          neg [3];
        logic [63:0] mx, s, len, q;
        logic signed [63:0] a;
        mx = 0;
        for (int k = 0; k < 3; k++) begin
            a = 64'(acc_mem[v][k]);
            neg[k] = a < 0;
            m[k] = neg[k] ? -a : a;
            if (m[k] > mx) mx = m[k];
            n[k] = '0;
        end
        if (mx == 0) return 1'b0;
        while (mx >= (64'd1 << 31)) begin
            for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
            mx = mx << 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(s);
        for (int k = 0; k < 3; k++) begin
            q = (m[k] * 16384 + len / 2) / len;
            if (q > 16384) q = 16384;
            n[k] = neg[k] ? -q[NRM_W-1:0] : q[NRM_W-1:0];
        end
        return 1'b1;
    endfunction

    // Work out the result of one item and update the mesh state.
    task automatic predict_normal(t_op op, logic [IDX_W-1:0] ia, ib, ic,
                                  logic signed [POS_W-1:0] px, py, pz);
        t_normal_exp e;
        logic signed [63:0] e1 [3], e2 [3], cr [3];
        logic [IDX_W-1:0]   cor [3];
        logic [NRM_W-1:0]   n [3];
        e.status = ST_OK;
        e.vidx = ia;
        e.nx = '0; e.ny = '0; e.nz = '0;
        case (op)
            OP_LOAD: begin
                if (!index_ok(ia)) e.status = ST_RANGE;
                else begin
                    pos_mem[ia][0] = px; pos_mem[ia][1] = py; pos_mem[ia][2] = pz;
                    for (int k = 0; k < 3; k++) acc_mem[ia][k] = '0;
                    loaded[ia] = 1'b1;
                end
            end
            OP_TRI: begin
                if (!index_ok(ia) || !index_ok(ib) || !index_ok(ic)) e.status = ST_RANGE;
                else begin
                    for (int k = 0; k < 3; k++) begin
                        e1[k] = 64'(pos_mem[ib][k]) - 64'(pos_mem[ia][k]);
                        e2[k] = 64'(pos_mem[ic][k]) - 64'(pos_mem[ia][k]);
                    end
                    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                    cor[0] = ia; cor[1] = ib; cor[2] = ic;
                    for (int j = 0; j < 3; j++)
                        for (int k = 0; k < 3; k++)
                            acc_mem[cor[j]][k] = sat_sum(acc_mem[cor[j]][k], cr[k]);
                end
            end
            OP_READ: begin
                if (!index_ok(ia)) e.status = ST_RANGE;
                else if (!unit_normal(ia, n)) e.status = ST_ZERO;
                else begin
                    e.nx = n[0]; e.ny = n[1]; e.nz = n[2];
                end
            end
            default: ;
        endcase
        normal_q.push_back(e);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    // Send one item; predict at the accepting edge. tvalid drops only when the
    // sender idles or stops, so an accepted item is followed at once by the next.
    task automatic send_item(t_op op, logic [IDX_W-1:0] ia, ib, ic,
                             logic signed [POS_W-1:0] px, py, pz);
        while (!tx_quiet && $urandom_range(99) < 12) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= op;
        i_s_axis_tdata  <= {2'b00, pz, py, px, ic, ib, ia};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_normal(op, ia, ib, ic, px, py, pz);
    endtask

    // Wait until all results are in, then let the block settle before a write.
    task automatic write_vertex_count(int unsigned v);
        i_s_axis_tvalid <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        vcount = v;
    endtask

    // Only vertices already loaded may be used as triangle corners.
    function automatic logic [IDX_W-1:0] pick_loaded(int unsigned lim);
        logic [IDX_W-1:0] i;
        for (int t = 0; t < 64; t++) begin
            i = IDX_W'($urandom_range(lim - 1));
            if (loaded[i]) return i;
        end
        for (int t = 0; t < int'(lim); t++) if (loaded[t]) return IDX_W'(t);
        return '0;
    endfunction

    // Result checker: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_normal_exp e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (normal_q.size() == 0) begin
                report_mismatch("unexpected result", o_m_axis_tdata, 0);
            end else begin
                e = normal_q.pop_front();
                if (o_m_axis_tuser != e.status)
                    report_mismatch("status", o_m_axis_tuser, e.status);
                if (o_m_axis_tdata[9:0] != e.vidx)
                    report_mismatch("vertex_index", o_m_axis_tdata[9:0], e.vidx);
                if (o_m_axis_tdata[25:10] != e.nx)
                    report_mismatch("norm_x", o_m_axis_tdata[25:10], e.nx);
                if (o_m_axis_tdata[41:26] != e.ny)
                    report_mismatch("norm_y", o_m_axis_tdata[41:26], e.ny);
                if (o_m_axis_tdata[57:42] != e.nz)
                    report_mismatch("norm_z", o_m_axis_tdata[57:42], e.nz);
                if (o_m_axis_tdata[63:58] != 0)
                    report_mismatch("fill", o_m_axis_tdata[63:58], 0);
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= rx_quiet || ($urandom_range(99) >= 12);
        end
    end

    // Directed: range edges, every opcode, zero normal, repeated corners, extremes.
    task automatic test_directed();
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);                 // zero accumulator
        send_item(OP_LOAD, 0, 0, 0, 0, 0, 0);
        send_item(OP_LOAD, 1, 0, 0, 16'sh7fff, 16'sh8000, 0);
        send_item(OP_LOAD, 2, 0, 0, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_item(OP_LOAD, 1023, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(OP_TRI, 0, 1, 2, 0, 0, 0);
        send_item(OP_TRI, 0, 1, 1023, 0, 0, 0);
        send_item(OP_TRI, 1, 1, 2, 0, 0, 0);                  // repeated corners
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 1, 0, 0, 0, 0, 0);
        send_item(OP_READ, 1023, 0, 0, 0, 0, 0);
        send_item(OP_NOP, 1023, 1023, 1023, -1, -1, -1);
        // add a triangle of extreme corner positions to the accumulators, repeatedly
        for (int i = 0; i < 6; i++) send_item(OP_TRI, 1, 2, 1023, 0, 0, 0);
        send_item(OP_READ, 2, 0, 0, 0, 0, 0);
        write_vertex_count(3);
        send_item(OP_LOAD, 3, 0, 0, 0, 0, 0);                 // just out of range
        send_item(OP_TRI, 0, 1, 3, 0, 0, 0);
        send_item(OP_READ, 3, 0, 0, 0, 0, 0);
        send_item(OP_READ, 2, 0, 0, 0, 0, 0);
        write_vertex_count(1);
        send_item(OP_TRI, 0, 0, 0, 0, 0, 0);
        send_item(OP_READ, 1, 0, 0, 0, 0, 0);
        write_vertex_count(0);
        send_item(OP_READ, 0, 0, 0, 0, 0, 0);
        write_vertex_count(2047);                            // above every index
    endtask

    // Random mesh work within the current vertex_count, plus some indices drawn at random.
    task automatic test_random_mesh(int n_items, int unsigned span);
        int unsigned lim, r;
        logic [IDX_W-1:0] a, b, c;
        lim = span < 1024 ? span : 1024;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 25 || !loaded[0]) begin
                a = (r < 3) ? IDX_W'($urandom) : IDX_W'($urandom_range(lim - 1));
                send_item(OP_LOAD, a, IDX_W'($urandom), IDX_W'($urandom),
                          POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            end else if (r < 65) begin
                a = pick_loaded(lim); b = pick_loaded(lim); c = pick_loaded(lim);
                if (r < 30) c = IDX_W'($urandom);           // possibly out of range
                if (c >= vcount || loaded[c])
                    send_item(OP_TRI, a, b, c, POS_W'($urandom), 0, 0);
            end else if (r < 95) begin
                a = (r < 70) ? IDX_W'($urandom) : pick_loaded(lim);
                send_item(OP_READ, a, 0, 0, 0, 0, 0);
            end else begin
                send_item(OP_NOP, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
                          POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    // Hold the receiver off for a long stretch while items keep coming.
    task automatic test_backpressure();
        hold_off = 400;
        test_random_mesh(30, vcount);
    endtask

    initial begin
        vcount = VCOUNT_RST;
        for (int i = 0; i < INDEX_SPAN; i++) begin
            loaded[i] = 1'b0;
            for (int k = 0; k < 3; k++) begin
                acc_mem[i][k] = '0;
                pos_mem[i][k] = '0;
            end
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mesh(300, vcount);
        test_backpressure();
        write_vertex_count(16);
        test_random_mesh(250, 16);
        write_vertex_count(1024);
        rx_quiet = 1'b1; tx_quiet = 1'b1;                    // stretch without idling
        test_random_mesh(150, 1024);
        rx_quiet = 1'b0; tx_quiet = 1'b0;
        write_vertex_count(5);
        test_random_mesh(280, 5);
        i_s_axis_tvalid <= 1'b0;
        while (normal_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit: a run that has not finished by the time-out counts as a mismatch.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
